### src/tppt_pkg.sv
package tppt_pkg;

    localparam int NUM_LINES = 1024;
    localparam int NUM_WAYS  = 4;
    localparam int NUM_TYPES = 16;

    localparam int LINE_W = $clog2(NUM_LINES);
    localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int TIDX_W = $clog2(NUM_TYPES);
    localparam int TREE_N = 1 << TIDX_W;

    localparam int TAG_W   = 32;
    localparam int CNT_W   = 8;
    localparam int TYPE_W  = 4;
    localparam int SUM_W   = 12;
    localparam int CFG_W   = 12;
    localparam int CNT_MAX = 255;
    localparam int SUM_MAX = 4095;
    localparam int THRESH_RESET = 199;

    localparam int SUM_FULL_W = CNT_W + TIDX_W;
    localparam int SUM_CMP_W  = (SUM_FULL_W > SUM_W) ? SUM_FULL_W : SUM_W;

    typedef logic [CNT_W-1:0] count_t;
    typedef count_t [NUM_TYPES-1:0] counts_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        count_t           total;
        counts_t          counts;
    } way_t;

    typedef way_t [NUM_WAYS-1:0] line_t;

    typedef enum logic [0:0] {
        KIND_RECORD  = 1'b0,
        KIND_PREDICT = 1'b1
    } kind_t;

    typedef enum logic [0:0] {
        CFG_PROFILING_ENABLED    = 1'b0,
        CFG_MIN_SAMPLE_THRESHOLD = 1'b1
    } cfg_addr_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_PRED
    } state_t;

    typedef struct packed {
        logic              predicted_valid;
        logic [TYPE_W-1:0] predicted_type;
        count_t            best_count;
        logic [SUM_W-1:0]  sample_sum;
    } pred_res_t;

endpackage

### src/tppt_in_if.sv
interface tppt_in_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [tppt_pkg::TAG_W-1:0]  key_hash;
    logic [tppt_pkg::TYPE_W-1:0] data_type;

    modport source (output valid, kind, key_hash, data_type, input ready);
    modport sink (input valid, kind, key_hash, data_type, output ready);
endinterface

### src/tppt_out_if.sv
interface tppt_out_if;
    logic                        valid;
    logic                        ready;
    logic                        predicted_valid;
    logic [tppt_pkg::TYPE_W-1:0] predicted_type;
    logic [tppt_pkg::CNT_W-1:0]  best_count;
    logic [tppt_pkg::SUM_W-1:0]  sample_sum;

    modport source (output valid, predicted_valid, predicted_type, best_count, sample_sum,
                    input ready);
    modport sink (input valid, predicted_valid, predicted_type, best_count, sample_sum,
                  output ready);
endinterface

### src/tppt_cfg_if.sv
interface tppt_cfg_if;
    logic                       valid;
    logic                       ready;
    tppt_pkg::cfg_addr_t        addr;
    logic [tppt_pkg::CFG_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

### src/tppt_line_ram.sv
module tppt_line_ram
(
    input  logic                        clk,
    input  logic                        we,
    input  logic [tppt_pkg::LINE_W-1:0] waddr,
    input  tppt_pkg::line_t             wdata,
    input  logic                        re,
    input  logic [tppt_pkg::LINE_W-1:0] raddr,
    output tppt_pkg::line_t             rdata
);

    tppt_pkg::line_t mem [tppt_pkg::NUM_LINES];
    tppt_pkg::line_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/tppt_pred.sv
module tppt_pred
(
    input  tppt_pkg::counts_t            counts,
    input  logic                         hit,
    input  logic [tppt_pkg::SUM_W-1:0]   thresh,
    output tppt_pkg::pred_res_t          res
);

    // heap-ordered trees, leaves at TREE_N..2*TREE_N-1
    logic [tppt_pkg::SUM_FULL_W-1:0] sum_node  [2*tppt_pkg::TREE_N];
    tppt_pkg::count_t                best_node [2*tppt_pkg::TREE_N];
    logic [tppt_pkg::TIDX_W-1:0]     idx_node  [2*tppt_pkg::TREE_N];
    logic [tppt_pkg::SUM_CMP_W-1:0]  sum_cmp;
    logic [tppt_pkg::SUM_CMP_W-1:0]  thresh_cmp;

    always_comb
    begin
        for (int n = 0; n < 2*tppt_pkg::TREE_N; n++)
        begin
            sum_node[n]  = '0;
            best_node[n] = '0;
            idx_node[n]  = '0;
        end
        for (int i = 0; i < tppt_pkg::TREE_N; i++)
        begin
            if (i < tppt_pkg::NUM_TYPES)
            begin
                sum_node[tppt_pkg::TREE_N + i]  = tppt_pkg::SUM_FULL_W'(counts[i]);
                best_node[tppt_pkg::TREE_N + i] = counts[i];
            end
            idx_node[tppt_pkg::TREE_N + i] = tppt_pkg::TIDX_W'(i);
        end
        for (int n = tppt_pkg::TREE_N - 1; n >= 1; n--)
        begin
            sum_node[n] = sum_node[2*n] + sum_node[2*n+1];
            // left side wins ties so the lowest type index is kept
            if (best_node[2*n+1] > best_node[2*n])
            begin
                best_node[n] = best_node[2*n+1];
                idx_node[n]  = idx_node[2*n+1];
            end
            else
            begin
                best_node[n] = best_node[2*n];
                idx_node[n]  = idx_node[2*n];
            end
        end

        sum_cmp    = tppt_pkg::SUM_CMP_W'(sum_node[1]);
        thresh_cmp = tppt_pkg::SUM_CMP_W'(thresh);

        res = '0;
        if (hit)
        begin
            if (sum_cmp > tppt_pkg::SUM_CMP_W'(tppt_pkg::SUM_MAX))
            begin
                res.sample_sum = tppt_pkg::SUM_W'(tppt_pkg::SUM_MAX);
            end
            else
            begin
                res.sample_sum = sum_cmp[tppt_pkg::SUM_W-1:0];
            end
            if (sum_cmp >= thresh_cmp && best_node[1] != '0)
            begin
                res.predicted_valid = 1'b1;
                res.predicted_type  = tppt_pkg::TYPE_W'(idx_node[1]);
                res.best_count      = best_node[1];
            end
        end
    end

endmodule

### src/type_profile_predictor_table.sv
// Type frequency table, 1024 lines of 4 ways, one way per 32-bit key. A line
// lives in one word of a simple dual-port synchronous RAM (tag, 8-bit total and
// 16 8-bit type counters per way). After reset the RAM is cleared one line per
// cycle, and the item channel stays stalled until every line is cleared;
// configuration writes are taken at any time. A record item reads the line, then
// compares, updates and writes it back, and produces no result. A predict item
// reads the line, selects the way, then sums the counts and finds the argmax,
// and waits for the result register to drain if it is still held. Only one item
// is in flight, so a read always sees the previous write back. A new item is
// accepted while a result still waits. Probability is left as the ratio best_count / sample_sum.
module type_profile_predictor_table
(
    input  logic        clk,
    input  logic        rst_n,
    tppt_in_if.sink     item,
    tppt_out_if.source  result,
    tppt_cfg_if.sink    cfg
);

    // configuration
    logic                       enabled_reg;
    logic [tppt_pkg::SUM_W-1:0] thresh_reg;

    // control
    tppt_pkg::state_t            state_reg, state_next;
    logic [tppt_pkg::LINE_W-1:0] clr_line_reg, clr_line_next;

    // captured item
    logic                        kind_reg;
    logic [tppt_pkg::TAG_W-1:0]  tag_reg;
    logic [tppt_pkg::TYPE_W-1:0] type_reg;

    // predict path
    tppt_pkg::counts_t   pcounts_reg, pcounts_next;
    logic                phit_reg, phit_next;
    tppt_pkg::pred_res_t pred_res;

    // result register
    logic                out_valid_reg, out_valid_next;
    tppt_pkg::pred_res_t out_reg, out_next;

    // line ram
    logic                        ram_we;
    logic [tppt_pkg::LINE_W-1:0] ram_waddr;
    tppt_pkg::line_t             ram_wdata;
    logic                        ram_re;
    tppt_pkg::line_t             ram_rdata;

    // exec stage
    logic                       hit_any;
    logic [tppt_pkg::WAY_W-1:0] hit_way;
    logic [tppt_pkg::WAY_W-1:0] victim_way;
    logic [tppt_pkg::WAY_W-1:0] sel_way;
    tppt_pkg::count_t           min_total;
    tppt_pkg::way_t             upd_way;
    logic                       type_ok;

    logic item_xfer;
    logic result_xfer;

    assign item_xfer   = item.valid && item.ready;
    assign result_xfer = result.valid && result.ready;

    // config writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            thresh_reg  <= tppt_pkg::SUM_W'(tppt_pkg::THRESH_RESET);
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.addr)
                tppt_pkg::CFG_PROFILING_ENABLED:    enabled_reg <= cfg.data[0];
                tppt_pkg::CFG_MIN_SAMPLE_THRESHOLD: thresh_reg  <= cfg.data;
                default:                            ;
            endcase
        end
    end

    tppt_line_ram u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (item.key_hash[tppt_pkg::LINE_W-1:0]),
        .rdata (ram_rdata)
    );

    // hit search and victim choice over the line just read
    always_comb
    begin
        hit_any    = 1'b0;
        hit_way    = '0;
        victim_way = '0;
        min_total  = tppt_pkg::CNT_W'(tppt_pkg::CNT_MAX);
        for (int w = tppt_pkg::NUM_WAYS - 1; w >= 0; w--)
        begin
            // descending loop so the first matching way wins
            if (ram_rdata[w].tag == tag_reg)
            begin
                hit_any = 1'b1;
                hit_way = tppt_pkg::WAY_W'(w);
            end
        end
        for (int w = 0; w < tppt_pkg::NUM_WAYS; w++)
        begin
            // strict compare keeps the first way with the smallest total below saturation
            if (ram_rdata[w].total < min_total)
            begin
                min_total  = ram_rdata[w].total;
                victim_way = tppt_pkg::WAY_W'(w);
            end
        end
        sel_way = hit_any ? hit_way : victim_way;
        type_ok = (int'(type_reg) < tppt_pkg::NUM_TYPES);

        // counter update of the chosen way, saturating at the top
        upd_way = ram_rdata[sel_way];
        if (!hit_any)
        begin
            upd_way.tag   = tag_reg;
            upd_way.total = '0;
        end
        if (upd_way.total != tppt_pkg::CNT_W'(tppt_pkg::CNT_MAX))
        begin
            upd_way.total = upd_way.total + 1'b1;
        end
        for (int t = 0; t < tppt_pkg::NUM_TYPES; t++)
        begin
            if (int'(type_reg) == t
                && upd_way.counts[t] != tppt_pkg::CNT_W'(tppt_pkg::CNT_MAX))
            begin
                upd_way.counts[t] = upd_way.counts[t] + 1'b1;
            end
        end
    end

    tppt_pred u_pred
    (
        .counts (pcounts_reg),
        .hit    (phit_reg),
        .thresh (thresh_reg),
        .res    (pred_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tppt_pkg::ST_CLEAR;
            clr_line_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_line_reg  <= clr_line_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            kind_reg <= item.kind;
            tag_reg  <= item.key_hash;
            type_reg <= item.data_type;
        end
        pcounts_reg <= pcounts_next;
        phit_reg    <= phit_next;
        out_reg     <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_line_next  = clr_line_reg;
        pcounts_next   = pcounts_reg;
        phit_next      = phit_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        item.ready     = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = tag_reg[tppt_pkg::LINE_W-1:0];
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;

        if (result_xfer)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            tppt_pkg::ST_CLEAR:
            begin
                // zero one line per cycle
                ram_we    = 1'b1;
                ram_waddr = clr_line_reg;
                ram_wdata = '0;
                clr_line_next = clr_line_reg + 1'b1;
                if (clr_line_reg == tppt_pkg::LINE_W'(tppt_pkg::NUM_LINES - 1))
                begin
                    state_next = tppt_pkg::ST_IDLE;
                end
            end
            tppt_pkg::ST_IDLE:
            begin
                item.ready = 1'b1;
                ram_re     = item.valid;
                if (item.valid)
                begin
                    state_next = tppt_pkg::ST_EXEC;
                end
            end
            tppt_pkg::ST_EXEC:
            begin
                if (kind_reg == tppt_pkg::KIND_RECORD)
                begin
                    if (enabled_reg && type_ok)
                    begin
                        ram_we             = 1'b1;
                        ram_wdata[sel_way] = upd_way;
                    end
                    state_next = tppt_pkg::ST_IDLE;
                end
                else
                begin
                    pcounts_next = ram_rdata[hit_way].counts;
                    phit_next    = enabled_reg && hit_any;
                    state_next   = tppt_pkg::ST_PRED;
                end
            end
            tppt_pkg::ST_PRED:
            begin
                // wait here while the previous result is still held
                if (!out_valid_reg || result.ready)
                begin
                    out_next       = pred_res;
                    out_valid_next = 1'b1;
                    state_next     = tppt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tppt_pkg::ST_IDLE;
            end
        endcase
    end

    assign result.valid           = out_valid_reg;
    assign result.predicted_valid = out_reg.predicted_valid;
    assign result.predicted_type  = out_reg.predicted_type;
    assign result.best_count      = out_reg.best_count;
    assign result.sample_sum      = out_reg.sample_sum;

endmodule

### test/tppt_tb_pkg.sv
`timescale 1ns / 100ps

package tppt_tb_pkg;

    import tppt_pkg::*;

    // mirror of the type frequency table plus the queue of predictions still owed
    class frequency_table_model;

        bit [TAG_W-1:0] tags [NUM_LINES*NUM_WAYS];
        bit [CNT_W-1:0] totals [NUM_LINES*NUM_WAYS];
        bit [CNT_W-1:0] counts [NUM_LINES*NUM_WAYS][NUM_TYPES];
        bit             enabled;
        bit [CFG_W-1:0] threshold;
        pred_res_t      pending_predictions[$];
        int unsigned    mismatches;

        function new();
            enabled    = 1'b0;
            threshold  = CFG_W'(THRESH_RESET);
            mismatches = 0;
        endfunction

        function void write_reg(cfg_addr_t addr, logic [CFG_W-1:0] data);
            case (addr)
                CFG_PROFILING_ENABLED:    enabled = data[0];
                CFG_MIN_SAMPLE_THRESHOLD: threshold = data;
                default:                  ;
            endcase
        endfunction

        function int unsigned pending();
            return pending_predictions.size();
        endfunction

        // one accepted input transfer
        function void observe_item(kind_t kind, logic [TAG_W-1:0] key,
                                   logic [TYPE_W-1:0] dtype);
            int                base;
            int                slot;
            int                victim;
            int unsigned       sum;
            int unsigned       best;
            int                best_type;
            logic [CNT_W-1:0]  low_total;
            pred_res_t         want;

            base = int'(key[LINE_W-1:0]) * NUM_WAYS;
            // first way whose tag matches
            slot = -1;
            for (int w = NUM_WAYS - 1; w >= 0; w--)
                if (tags[base + w] == key)
                    slot = base + w;

            if (kind == KIND_RECORD)
            begin
                if (!enabled || dtype >= NUM_TYPES)
                    return;
                if (slot < 0)
                begin
                    // first way with the smallest unsaturated total, else way 0
                    victim    = 0;
                    low_total = CNT_W'(CNT_MAX);
                    for (int w = 0; w < NUM_WAYS; w++)
                    begin
                        if (totals[base + w] < low_total)
                        begin
                            low_total = totals[base + w];
                            victim    = w;
                        end
                    end
                    slot         = base + victim;
                    tags[slot]   = key;
                    totals[slot] = '0;
                end
                if (counts[slot][dtype] != CNT_W'(CNT_MAX))
                    counts[slot][dtype]++;
                if (totals[slot] != CNT_W'(CNT_MAX))
                    totals[slot]++;
                return;
            end

            want = '0;
            if (enabled && slot >= 0)
            begin
                sum = 0;
                for (int t = 0; t < NUM_TYPES; t++)
                    sum += counts[slot][t];
                want.sample_sum = (sum > SUM_MAX) ? SUM_W'(SUM_MAX) : SUM_W'(sum);
                if (sum >= threshold)
                begin
                    best      = 0;
                    best_type = 0;
                    for (int t = 0; t < NUM_TYPES; t++)
                    begin
                        if (counts[slot][t] > best)
                        begin
                            best      = counts[slot][t];
                            best_type = t;
                        end
                    end
                    if (best != 0)
                    begin
                        want.predicted_valid = 1'b1;
                        want.predicted_type  = TYPE_W'(best_type);
                        want.best_count      = CNT_W'(best);
                    end
                end
            end
            pending_predictions.push_back(want);
        endfunction

        // one accepted result transfer against the oldest owed prediction
        function void compare_prediction(pred_res_t got);
            pred_res_t want;

            if (pending_predictions.size() == 0)
            begin
                $error("result with no prediction owed: valid %0d type %0d count %0d sum %0d",
                       got.predicted_valid, got.predicted_type, got.best_count,
                       got.sample_sum);
                mismatches++;
                return;
            end
            want = pending_predictions.pop_front();
            if (got.predicted_valid !== want.predicted_valid)
            begin
                $error("predicted_valid: expected %0d, got %0d",
                       want.predicted_valid, got.predicted_valid);
                mismatches++;
            end
            if (got.predicted_type !== want.predicted_type)
            begin
                $error("predicted_type: expected %0d, got %0d",
                       want.predicted_type, got.predicted_type);
                mismatches++;
            end
            if (got.best_count !== want.best_count)
            begin
                $error("best_count: expected %0d, got %0d", want.best_count, got.best_count);
                mismatches++;
            end
            if (got.sample_sum !== want.sample_sum)
            begin
                $error("sample_sum: expected %0d, got %0d", want.sample_sum, got.sample_sum);
                mismatches++;
            end
        endfunction

    endclass

endpackage

### test/type_profile_predictor_table_tb.sv
`timescale 1ns / 100ps

module type_profile_predictor_table_tb;

    import tppt_pkg::*;
    import tppt_tb_pkg::*;

    // cycles with no transfer at all before the run is declared hung
    // (covers the post-reset clearing pass and the long receiver hold-off)
    localparam int QUIET_LIMIT = 4000;
    // settle time after the last owed result, records produce none
    localparam int SETTLE      = 8;
    localparam int POOL_SIZE   = 24;
    localparam int HOLD_CYCLES = 200;

    logic clk;
    logic rst_n;

    tppt_in_if  item_if ();
    tppt_out_if res_if ();
    tppt_cfg_if cfg_if ();

    type_profile_predictor_table u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    frequency_table_model table_model;

    // idle knobs, percent of cycles
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    // hold-off request to the result receiver and its own countdown
    int unsigned hold_req;
    bit          hold_taken;
    int unsigned hold_left;
    int unsigned quiet_cycles;

    logic [TAG_W-1:0] key_pool [POOL_SIZE];
    pred_res_t        seen_result;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // result receiver: random stalls, plus one long hold-off on request
    initial
    begin
        res_if.ready = 1'b0;
        hold_left    = 0;
        hold_taken   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                res_if.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req != 0 && !hold_taken)
            begin
                res_if.ready <= 1'b0;
                hold_left  = hold_req - 1;
                hold_taken = 1'b1;
            end
            else
                res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // transfer monitor: config and input transfers update the model,
    // result transfers are checked against the oldest owed prediction
    always @(posedge clk)
    begin
        if (res_if.valid && res_if.ready)
        begin
            seen_result.predicted_valid = res_if.predicted_valid;
            seen_result.predicted_type  = res_if.predicted_type;
            seen_result.best_count      = res_if.best_count;
            seen_result.sample_sum      = res_if.sample_sum;
            table_model.compare_prediction(seen_result);
        end
        if (cfg_if.valid && cfg_if.ready)
            table_model.write_reg(cfg_if.addr, cfg_if.data);
        if (item_if.valid && item_if.ready)
            table_model.observe_item(kind_t'(item_if.kind), item_if.key_hash,
                                     item_if.data_type);
    end

    // watchdog on cycles without any transfer
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // offer one item, return at the edge where it is transferred
    // valid stays high into the next item unless an idle gap is drawn
    task automatic send_item(kind_t kind, logic [TAG_W-1:0] key, logic [TYPE_W-1:0] dtype);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid     <= 1'b1;
        item_if.kind      <= kind;
        item_if.key_hash  <= key;
        item_if.data_type <= dtype;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
    endtask

    // stop offering and wait for every owed prediction, then let records finish;
    // the monitor first gets to log the last transfer
    task automatic drain();
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (table_model.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // both registers, back to back, only while the table is idle
    task automatic set_config(bit enable, logic [CFG_W-1:0] thresh);
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= CFG_PROFILING_ENABLED;
        cfg_if.data  <= CFG_W'(enable);
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.addr  <= CFG_MIN_SAMPLE_THRESHOLD;
        cfg_if.data  <= thresh;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // mixed traffic over a small pool of colliding keys, a little noise
    // each key leans toward one or two types so predictions settle
    task automatic run_mixed(int unsigned count);
        logic [TAG_W-1:0]  key;
        logic [TYPE_W-1:0] dtype;

        for (int unsigned n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 6)
                key = $urandom();
            else
                key = key_pool[$urandom_range(POOL_SIZE - 1)];
            if ($urandom_range(3) == 0)
                dtype = TYPE_W'($urandom_range(NUM_TYPES - 1));
            else
                dtype = key[25:22] + TYPE_W'($urandom_range(1));
            if ($urandom_range(99) < 55)
                send_item(KIND_RECORD, key, dtype);
            else
                send_item(KIND_PREDICT, key, dtype);
        end
    endtask

    initial
    begin
        logic [LINE_W-1:0] sat_line;
        logic [LINE_W-1:0] pool_line;
        logic [TAG_W-1:0]  sat_keys [5];

        table_model = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 0;

        rst_n             = 1'b0;
        item_if.valid     = 1'b0;
        item_if.kind      = KIND_RECORD;
        item_if.key_hash  = '0;
        item_if.data_type = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.addr       = CFG_PROFILING_ENABLED;
        cfg_if.data       = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: profiling off after reset, record ignored, predict all zero
        send_item(KIND_RECORD, 32'h0000_0005, 4'd3);
        send_item(KIND_PREDICT, 32'h0000_0005, 4'd0);
        drain();

        // threshold 0: key 0 hits a cleared way with no nonzero counter,
        // then a tie between the lowest and highest type
        set_config(1'b1, 12'd0);
        send_item(KIND_PREDICT, 32'h0000_0000, 4'd0);
        send_item(KIND_RECORD, 32'h0000_0000, 4'd15);
        send_item(KIND_RECORD, 32'h0000_0000, 4'd0);
        send_item(KIND_PREDICT, 32'h0000_0000, 4'd15);
        drain();

        // sum exactly at threshold, below threshold, predict miss
        set_config(1'b1, 12'd2);
        send_item(KIND_RECORD, 32'hFFFF_FFFF, 4'd15);
        send_item(KIND_RECORD, 32'hFFFF_FFFF, 4'd15);
        send_item(KIND_PREDICT, 32'hFFFF_FFFF, 4'd0);
        send_item(KIND_RECORD, 32'h8000_03FF, 4'd7);
        send_item(KIND_PREDICT, 32'h8000_03FF, 4'd7);
        send_item(KIND_PREDICT, 32'h1234_5678, 4'd0);
        drain();

        // threshold 4080, plus a miss that lands in the emptiest way of line 0
        set_config(1'b1, 12'd4080);
        send_item(KIND_PREDICT, 32'hFFFF_FFFF, 4'd0);
        send_item(KIND_RECORD, 32'h0000_0400, 4'd9);
        send_item(KIND_PREDICT, 32'h0000_0400, 4'd9);
        drain();

        // saturation: four keys on one fresh line, 255 records each, so every
        // total sticks at 255 and the fifth key must evict way 0
        set_config(1'b1, 12'd199);
        sat_line = LINE_W'($urandom_range(NUM_LINES - 2, 1));
        for (int k = 0; k < 5; k++)
            sat_keys[k] = (((TAG_W'($urandom()) & ~32'h7) | TAG_W'(k)) << LINE_W) |
                          TAG_W'(sat_line);
        for (int r = 0; r < 4 * CNT_MAX; r++)
        begin
            send_item(KIND_RECORD, sat_keys[r % 4], TYPE_W'($urandom_range(NUM_TYPES - 1)));
            if ($urandom_range(31) == 0)
                send_item(KIND_PREDICT, sat_keys[$urandom_range(3)], 4'd0);
        end
        send_item(KIND_RECORD, sat_keys[4], TYPE_W'($urandom_range(NUM_TYPES - 1)));
        send_item(KIND_PREDICT, sat_keys[4], 4'd0);
        send_item(KIND_PREDICT, sat_keys[0], 4'd0);
        send_item(KIND_PREDICT, sat_keys[1], 4'd0);
        drain();

        // key pool: four lines, six keys each, more keys than ways
        for (int l = 0; l < 4; l++)
        begin
            pool_line = LINE_W'($urandom_range(NUM_LINES - 1));
            for (int k = 0; k < POOL_SIZE / 4; k++)
                key_pool[l * (POOL_SIZE / 4) + k] = (TAG_W'($urandom()) << LINE_W) |
                                                    TAG_W'(pool_line);
        end

        // sender idles
        send_idle_pct = 54;
        set_config(1'b1, CFG_W'($urandom_range(12, 1)));
        run_mixed(40);
        drain();

        // receiver stalls
        send_idle_pct  = 0;
        recv_stall_pct = 54;
        set_config(1'b1, CFG_W'($urandom_range(6)));
        run_mixed(40);
        drain();

        // profiling off: records ignored, predictions all zero
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        set_config(1'b0, 12'd4080);
        run_mixed(20);
        drain();

        // both sides idle, threshold 0
        set_config(1'b1, 12'd0);
        run_mixed(40);
        drain();

        // back-pressure: receiver holds off while items keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_config(1'b1, 12'd3);
        hold_req = HOLD_CYCLES;
        run_mixed(60);
        drain();

        if (table_model.mismatches == 0 && table_model.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
